@@ rtl/hsc_pkg.sv @@
`default_nettype none

package hsc_pkg;

   // Width of the request and response words, and of the r setting
   localparam int WORD_W = 63;
   localparam int CFG_W  = 3;

   // Parity bit count limits
   localparam int MIN_PARITY_BITS     = 2;
   localparam int MAX_PARITY_BITS_DEF = 6;
   localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

   typedef enum logic {
      ACT_ENCODE = 1'b0,
      ACT_DECODE = 1'b1
   } action_type;

   typedef struct packed {
      action_type        action;
      logic [WORD_W-1:0] word_in;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] word_out;
      logic              corrected;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/hsc_syndrome.sv @@
`default_nettype none

// XOR of the positions (numbered from 1) of all set bits.
module hsc_syndrome #(
   parameter int MAX_PARITY_BITS = hsc_pkg::MAX_PARITY_BITS_DEF
) (
   input  wire logic [(1 << MAX_PARITY_BITS)-2:0] code,
   output logic      [MAX_PARITY_BITS-1:0]        syn
);

   localparam int CODE_W = (1 << MAX_PARITY_BITS) - 1;

   always_comb begin
      syn = '0;
      for (int p = 1; p <= CODE_W; p++) begin
         if (code[p-1]) begin
            syn = syn ^ MAX_PARITY_BITS'(p);
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/hsc_core.sv @@
`default_nettype none

// Encode / decode datapath: scatter, syndrome, correct, gather.
module hsc_core #(
   parameter int MAX_PARITY_BITS = hsc_pkg::MAX_PARITY_BITS_DEF
) (
   input  wire hsc_pkg::action_type                  action,
   input  wire logic [MAX_PARITY_BITS-1:0]           code_len,
   input  wire logic [(1 << MAX_PARITY_BITS)-2:0]    word_in,
   output logic      [(1 << MAX_PARITY_BITS)-2:0]    word_out,
   output logic                                      corrected
);

   localparam int CODE_W = (1 << MAX_PARITY_BITS) - 1;
   localparam int DATA_W = CODE_W - MAX_PARITY_BITS;

   logic [CODE_W-1:0]          code_mask;
   logic [CODE_W-1:0]          scat;
   logic [CODE_W-1:0]          par;
   logic [CODE_W-1:0]          masked;
   logic [CODE_W-1:0]          fixed;
   logic [CODE_W-1:0]          syn_src;
   logic [DATA_W-1:0]          gath;
   logic [MAX_PARITY_BITS-1:0] syn;

   always_comb begin
      for (int j = 0; j < CODE_W; j++) begin
         code_mask[j] = (MAX_PARITY_BITS'(j) < code_len);
      end
   end

   assign masked = word_in & code_mask;

   // data bit k sits at the k-th position that is not a power of two
   for (genvar p = 1; p <= CODE_W; p++) begin : g_pos
      if ((p & (p - 1)) != 0) begin : g_data
         localparam int K = p - $clog2(p + 1) - 1;
         assign scat[p-1] = word_in[K] & code_mask[p-1];
         assign gath[K]   = fixed[p-1];
      end else begin : g_par
         assign scat[p-1] = 1'b0;
      end
   end

   assign syn_src = (action == hsc_pkg::ACT_ENCODE) ? scat : masked;

   hsc_syndrome #(
      .MAX_PARITY_BITS(MAX_PARITY_BITS)
   ) u_syndrome (
      .code(syn_src),
      .syn (syn)
   );

   always_comb begin
      par = '0;
      for (int i = 0; i < MAX_PARITY_BITS; i++) begin
         par[(1 << i) - 1] = syn[i];
      end
   end

   // syndrome of a masked word never points past the code length
   always_comb begin
      for (int j = 0; j < CODE_W; j++) begin
         fixed[j] = masked[j] ^ (syn == MAX_PARITY_BITS'(j + 1));
      end
   end

   always_comb begin
      if (action == hsc_pkg::ACT_ENCODE) begin
         word_out  = scat | par;
         corrected = 1'b0;
      end else begin
         word_out  = CODE_W'(gath);
         corrected = (syn != '0);
      end
   end

endmodule

`default_nettype wire

@@ rtl/hamming_sec_codec.sv @@
`default_nettype none

// Hamming single-error-correcting codec.
//
// Request channel: a word (action, word_in) is taken at each rising edge with
// start high; busy is tied low, so a word can be issued every cycle.
// action = encode: the low n-r data bits of word_in are spread into the
// non-power-of-two positions of an n = 2^r-1 bit code word and the parity
// bits are filled in. action = decode: the syndrome is formed, a nonzero
// syndrome flips the addressed bit and raises corrected, and the data bits
// are packed back down to the LSBs.
// Response channel: each result is shown for one cycle with rsp_strobe high.
// The receiver cannot stall; results come out in request order.
// Path: input register, XOR trees, result register. Throughput: 1 word per
// cycle, set by the single pass through the syndrome tree.
// Configuration: csr_we writes r (parity bit count) from csr_wdata; values
// below 2 act as 2, above MAX_PARITY_BITS as MAX_PARITY_BITS. Write only while
// no word is in flight.
// Reset (synchronous): clears the pipeline valids and sets r to 3.
module hamming_sec_codec #(
   parameter int MAX_PARITY_BITS = hsc_pkg::MAX_PARITY_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire hsc_pkg::req_type            req_word,
   output logic                             rsp_strobe,
   output hsc_pkg::rsp_type                 rsp_word,
   input  wire logic                        csr_we,
   input  wire logic [hsc_pkg::CFG_W-1:0]   csr_wdata
);

   localparam int CODE_W = (1 << MAX_PARITY_BITS) - 1;
   localparam int N_W    = MAX_PARITY_BITS;

   logic [hsc_pkg::CFG_W-1:0] csr_ff;
   logic [hsc_pkg::CFG_W-1:0] r_eff;
   logic [N_W-1:0]            code_len;
   logic [N_W-1:0]            data_len;

   hsc_pkg::req_type req_ff;
   logic             req_vld_ff;
   hsc_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_vld_ff;

   logic [CODE_W-1:0] core_word;
   logic              core_corr;

   // no back-pressure anywhere in the pipe
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= hsc_pkg::CFG_RESET;
      end else if (csr_we) begin
         csr_ff <= csr_wdata;
      end
   end

   // clamp r into the supported range
   always_comb begin
      if (csr_ff < hsc_pkg::CFG_W'(hsc_pkg::MIN_PARITY_BITS)) begin
         r_eff = hsc_pkg::CFG_W'(hsc_pkg::MIN_PARITY_BITS);
      end else if (csr_ff > hsc_pkg::CFG_W'(MAX_PARITY_BITS)) begin
         r_eff = hsc_pkg::CFG_W'(MAX_PARITY_BITS);
      end else begin
         r_eff = csr_ff;
      end
   end

   assign code_len = N_W'((1 << r_eff) - 1);
   assign data_len = code_len - N_W'(r_eff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~busy) begin
         req_ff <= req_word;
      end
   end

   hsc_core #(
      .MAX_PARITY_BITS(MAX_PARITY_BITS)
   ) u_core (
      .action   (req_ff.action),
      .code_len (code_len),
      .word_in  (req_ff.word_in[CODE_W-1:0]),
      .word_out (core_word),
      .corrected(core_corr)
   );

   always_comb begin
      rsp_in.word_out  = hsc_pkg::WORD_W'(core_word);
      rsp_in.corrected = core_corr;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_word   = rsp_ff;

   // checks
   logic [hsc_pkg::WORD_W-1:0] code_mask_chk;
   logic [hsc_pkg::WORD_W-1:0] data_mask_chk;

   always_comb begin
      for (int j = 0; j < hsc_pkg::WORD_W; j++) begin
         code_mask_chk[j] = (j < int'(code_len));
         data_mask_chk[j] = (j < int'(data_len));
      end
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted word did not produce a result two cycles later");

   a_enc_no_corr: assert property (@(posedge clock) disable iff (reset)
      $past(req_vld_ff && req_ff.action == hsc_pkg::ACT_ENCODE) |-> !rsp_word.corrected)
      else $error("encode result flagged a correction");

   a_enc_len: assert property (@(posedge clock) disable iff (reset)
      $past(req_vld_ff && req_ff.action == hsc_pkg::ACT_ENCODE)
         |-> ((rsp_word.word_out & ~$past(code_mask_chk)) == '0))
      else $error("encode result has bits beyond the code length");

   a_dec_len: assert property (@(posedge clock) disable iff (reset)
      $past(req_vld_ff && req_ff.action == hsc_pkg::ACT_DECODE)
         |-> ((rsp_word.word_out & ~$past(data_mask_chk)) == '0))
      else $error("decode result has bits beyond the data length");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import hsc_pkg::*;

   localparam int MAX_R         = MAX_PARITY_BITS_DEF;
   // Pipeline is an input register and a result register; wait for it to be quiet before touching r.
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 8;

   // Work list entries: a word to send, a new r to write, or a pause until
   // the pipeline has drained.
   typedef enum logic [1:0] {
      PEND_WORD,
      PEND_SET_R,
      PEND_DRAIN
   } pend_kind_type;

   typedef struct packed {
      pend_kind_type kind;
      req_type       word;
      logic [2:0]    r_val;
      logic          steady;   // 1: send back to back, never idle
   } pend_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_word = '0;
   logic             rsp_strobe;
   rsp_type          rsp_word;
   logic             csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   pend_type    pending[$];
   rsp_type     expected_codes[$];
   logic [2:0]  r_setting = CFG_RESET;   // r as the codec should hold it
   logic [2:0]  fill_r = CFG_RESET;      // r as seen while building the work list
   logic        word_taken = 1'b0;
   int          quiet_cycles = 0;
   int          mismatch_count = 0;

   hamming_sec_codec i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Register values outside 2..MAX_R are clamped by the codec.
   function automatic int eff_parity(input logic [2:0] r_raw);
      int r;
      r = r_raw;
      if (r < 2) r = 2;
      if (r > MAX_R) r = MAX_R;
      return r;
   endfunction

   // Golden Hamming encode / decode-and-correct for one word.
   function automatic rsp_type hamming_predict(input logic [2:0] r_raw, input req_type w);
      int unsigned r, n, syn, k;
      logic [WORD_W-1:0] word, code;
      rsp_type res;
      r = eff_parity(r_raw);
      n = (1 << r) - 1;
      word = w.word_in;
      code = '0;
      syn = 0;
      k = 0;
      res = '0;
      if (w.action == ACT_ENCODE) begin
         // spread data into non-power-of-two slots, track the parity syndrome
         for (int unsigned pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
               if (word[k]) begin
                  code[pos-1] = 1'b1;
                  syn ^= pos;
               end
               k++;
            end
         end
         for (int unsigned i = 0; i < r; i++)
            if (((syn >> i) & 1) != 0) code[(1 << i) - 1] = 1'b1;
         res.word_out = code;
      end else begin
         // bits above position n never enter the syndrome
         for (int unsigned pos = 1; pos <= n; pos++)
            if (word[pos-1]) syn ^= pos;
         if (syn != 0) begin
            word[syn-1] = ~word[syn-1];
            res.corrected = 1'b1;
         end
         for (int unsigned pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
               code[k] = word[pos-1];
               k++;
            end
         end
         res.word_out = code;
      end
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] rand63();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[WORD_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Work list builders
   // ---------------------------------------------------------------------
   task automatic queue_word(input action_type act, input logic [WORD_W-1:0] w,
                             input logic steady);
      pend_type e;
      e = '0;
      e.kind = PEND_WORD;
      e.word.action = act;
      e.word.word_in = w;
      e.steady = steady;
      pending.push_back(e);
   endtask

   task automatic queue_set_r(input logic [2:0] v);
      pend_type e;
      e = '0;
      e.kind = PEND_SET_R;
      e.r_val = v;
      pending.push_back(e);
      fill_r = v;
   endtask

   task automatic queue_drain();
      pend_type e;
      e = '0;
      e.kind = PEND_DRAIN;
      pending.push_back(e);
   endtask

   // Decode word built from a proper code word, with an optional single bit
   // error (err_pos 0 = clean) and optional junk above the code length.
   task automatic queue_code(input logic [WORD_W-1:0] data, input int err_pos,
                             input logic [WORD_W-1:0] junk, input logic steady);
      req_type     enc;
      rsp_type     enc_res;
      logic [63:0] in_mask;
      logic [WORD_W-1:0] code;
      int n;
      n = (1 << eff_parity(fill_r)) - 1;
      enc.action = ACT_ENCODE;
      enc.word_in = data;
      enc_res = hamming_predict(fill_r, enc);
      code = enc_res.word_out;
      if (err_pos != 0) code[err_pos-1] = ~code[err_pos-1];
      in_mask = (64'd1 << n) - 1;
      code = code | (junk & ~in_mask[WORD_W-1:0]);
      queue_word(ACT_DECODE, code, steady);
   endtask

   // Mostly well-formed traffic: encodes and clean / single-error code words,
   // the rest raw noise that may carry several errors.
   task automatic random_phase(input int count, input logic steady, input int drain_at);
      int r, n, roll, err;
      logic [63:0] dmask;
      logic [WORD_W-1:0] data;
      r = eff_parity(fill_r);
      n = (1 << r) - 1;
      dmask = (64'd1 << (n - r)) - 1;
      for (int i = 0; i < count; i++) begin
         if (i == drain_at) queue_drain();
         roll = $urandom_range(99);
         if (roll < 30) begin
            data = rand63();
            if ($urandom_range(1) == 1) data = data & dmask[WORD_W-1:0];
            queue_word(ACT_ENCODE, data, steady);
         end else if (roll < 80) begin
            err = ($urandom_range(2) == 0) ? 0 : $urandom_range(n, 1);
            queue_code(rand63(), err, ($urandom_range(3) == 0) ? rand63() : '0, steady);
         end else begin
            queue_word(action_type'($urandom_range(1)), rand63(), steady);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus: directed corners first, then random phases over several r.
   // ---------------------------------------------------------------------
   initial begin
      // r = 3 out of reset: all-zero / all-one words, errors on parity
      // positions, on data positions, on the top position, and junk above n.
      queue_word(ACT_ENCODE, '0, 1'b0);
      queue_word(ACT_ENCODE, '1, 1'b0);
      queue_word(ACT_DECODE, '0, 1'b0);
      queue_word(ACT_DECODE, '1, 1'b0);
      queue_code(63'h5, 1, '0, 1'b0);
      queue_code(63'h5, 4, '0, 1'b0);
      queue_code(63'h9, 5, '0, 1'b0);
      queue_code(63'h9, 7, '0, 1'b0);
      queue_code(63'hA, 0, '1, 1'b0);

      // widest code
      queue_set_r(3'd6);
      queue_word(ACT_ENCODE, '1, 1'b0);
      queue_code('1, 63, '0, 1'b0);
      queue_code(rand63(), 32, '0, 1'b0);
      queue_code('1, 0, '0, 1'b0);

      // narrowest code
      queue_set_r(3'd2);
      queue_word(ACT_ENCODE, '1, 1'b0);
      queue_word(ACT_DECODE, 63'h7, 1'b0);
      queue_code(63'h1, 3, '0, 1'b0);
      queue_code('0, 2, '0, 1'b0);

      // out-of-range settings clamp to 2 and MAX_R
      queue_set_r(3'd0);
      queue_code(63'h1, 1, '0, 1'b0);
      queue_word(ACT_DECODE, '1, 1'b0);
      queue_set_r(3'd7);
      queue_code('1, 48, '0, 1'b0);
      queue_word(ACT_ENCODE, rand63(), 1'b0);

      queue_set_r(3'd4);
      random_phase(100, 1'b0, -1);
      queue_set_r(3'd5);
      random_phase(100, 1'b0, 50);        // sender holds off until drained
      queue_set_r(3'd6);
      random_phase(100, 1'b1, -1);        // back-to-back stretch
      queue_set_r(3'd1);
      random_phase(100, 1'b0, -1);
      queue_set_r(3'd3);
      random_phase(100, 1'b0, -1);
      queue_set_r(3'd7);
      random_phase(100, 1'b0, -1);
      queue_set_r(3'd2);
      random_phase(100, 1'b0, -1);
      queue_set_r(3'd6);
      random_phase(100, 1'b0, -1);

      // hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // done once the list is empty and the codec has been quiet a while;
      // a result that never arrives keeps quiet_cycles at zero -> timeout
      @(posedge clock);
      while (pending.size() != 0 || quiet_cycles < END_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** hamming_sec_codec: PASSED **");
      else
         $display("** hamming_sec_codec: FAILED **");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for codec results");
      $display("** hamming_sec_codec: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: falling edge. Holds a word until taken, otherwise pulls the
   // next entry. r writes and drains wait for a quiet pipeline.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      pend_type         head;
      logic             nxt_start;
      logic             nxt_we;
      logic [CFG_W-1:0] nxt_wdata;
      req_type          nxt_req;
      nxt_start = 1'b0;
      nxt_req   = req_word;
      nxt_we    = 1'b0;
      nxt_wdata = csr_wdata;
      if (reset) begin
         nxt_start = 1'b0;
      end else if (start && !word_taken) begin
         nxt_start = 1'b1;              // not yet taken, keep presenting it
      end else if (pending.size() != 0) begin
         head = pending[0];
         case (head.kind)
            PEND_WORD: begin
               if (head.steady || $urandom_range(99) >= 36) begin
                  nxt_start = 1'b1;
                  nxt_req   = head.word;
                  void'(pending.pop_front());
               end
            end
            PEND_SET_R: begin
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  nxt_we    = 1'b1;
                  nxt_wdata = head.r_val;
                  void'(pending.pop_front());
               end
            end
            default: begin
               if (quiet_cycles >= SETTLE_CYCLES) void'(pending.pop_front());
            end
         endcase
      end
      start     <= nxt_start;
      req_word  <= nxt_req;
      csr_we    <= nxt_we;
      csr_wdata <= nxt_wdata;
   end

   // ---------------------------------------------------------------------
   // Monitor: rising edge. Checks the strobed result against the oldest
   // prediction, then predicts for a word taken at this edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      logic    took;
      took = !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         if (expected_codes.size() == 0) begin
            report_mismatch("result with none pending", rsp_word.word_out, '0);
         end else begin
            want = expected_codes.pop_front();
            if (rsp_word.word_out !== want.word_out)
               report_mismatch("word_out", rsp_word.word_out, want.word_out);
            if (rsp_word.corrected !== want.corrected)
               report_mismatch("corrected", WORD_W'(rsp_word.corrected),
                               WORD_W'(want.corrected));
         end
      end
      if (took) expected_codes.push_back(hamming_predict(r_setting, req_word));
      word_taken <= took;
      if (reset)
         r_setting <= CFG_RESET;
      else if (csr_we)
         r_setting <= csr_wdata;
      if (reset || took || expected_codes.size() != 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

endmodule

@@ filelist.f @@
rtl/hsc_pkg.sv
rtl/hsc_syndrome.sv
rtl/hsc_core.sv
rtl/hamming_sec_codec.sv
dv/tb_top.sv
